FILE: rtl/ptmi_pkg.sv
// ----------------------------------------------------------------------------
// Page table mapping inserter package
// Shared types, status codes and sizes for the page table inserter.
// ----------------------------------------------------------------------------
`default_nettype none

package ptmi_pkg;

   // Default number of 64-bit words in the table memory.
   localparam int TableMemWords = 65536;
   // Page sizes in bytes.
   localparam longint PAGE_BYTES = 4096;
   localparam longint HUGE_BYTES = 2097152;
   // Entries in one table page.
   localparam int TableEntries = 512;

   // Status codes.
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_VADDR_ALIGN = 3'd1;
   localparam logic [2:0] ST_SIZE_ALIGN  = 3'd2;
   localparam logic [2:0] ST_PADDR_ALIGN = 3'd3;
   localparam logic [2:0] ST_SPAN        = 3'd4;
   localparam logic [2:0] ST_PRESENT     = 3'd5;
   localparam logic [2:0] ST_UNDER_HUGE  = 3'd6;
   localparam logic [2:0] ST_NO_MEMORY   = 3'd7;

   // One mapping request.
   typedef struct packed {
      logic [63:0] virt_addr;
      logic [51:0] phys_addr;
      logic [30:0] span_bytes;
      logic [51:0] table_base;
      logic        writable;
      logic        huge_pages;
      logic        skip_vaddr_align;
   } req_type;

   // One result.
   typedef struct packed {
      logic [2:0] status;
      logic [9:0] leaves_written;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/page_table_mapping_inserter.sv
// ----------------------------------------------------------------------------
// Page table mapping inserter
// Maps a virtual range into a four-level page table held in an internal
// table memory, walking PML4, PDP and PD levels and writing leaf entries.
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  request   start, busy, req_data              start & !busy
//  result    rsp_valid, rsp_data                one-cycle strobe
//  config    csr_psel/penable/pwrite/paddr/...  APB, pready always high
//
// A request that fails its checks answers in the cycle after acceptance and
// never raises busy. A walk reads each table level's entry and then writes it
// back through the single memory port, reads and writes each leaf entry in
// turn and ends with a final check; with 2 MB pages the PD entries are the
// leaves. The result strobes in the same cycle as busy falls.
// After reset the table memory is cleared one word a cycle, with busy high.
// The receiver cannot stall, so results never wait.
`default_nettype none

module page_table_mapping_inserter
   import ptmi_pkg::*;
#(
   parameter int TABLE_MEM_WORDS = TableMemWords
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int AW = $clog2(TABLE_MEM_WORDS);
   localparam logic [AW-1:0] LAST_WORD = AW'(TABLE_MEM_WORDS - 1);
   localparam logic [40:0] PN_MAX = 41'((TABLE_MEM_WORDS - TableEntries) / TableEntries);
   localparam logic [31:0] REACH_SMALL = 32'(HUGE_BYTES);
   localparam logic [31:0] REACH_HUGE = 32'(TableEntries * HUGE_BYTES);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_WR    = 3'd3;

   localparam logic [1:0] LV_PML4 = 2'd0;
   localparam logic [1:0] LV_PDP  = 2'd1;
   localparam logic [1:0] LV_PD   = 2'd2;
   localparam logic [1:0] LV_LEAF = 2'd3;

   logic [63:0] mem [TABLE_MEM_WORDS];
   logic [63:0] mem_rdata_ff;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [51:0]   top_ff;
   logic [1:0]    level_ff, level_in;
   logic [40:0]   cur_pn_ff, cur_pn_in;
   logic [39:0]   tb_pn_ff, tb_pn_in;
   logic [39:0]   leaf_pn_ff, leaf_pn_in;
   logic [35:0]   va_ff, va_in;
   logic          rw_ff, rw_in;
   logic          huge_ff, huge_in;
   logic [9:0]    n_ff, n_in;
   logic [9:0]    cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [63:0]   mem_wdata;

   logic [29:0] va_off;
   logic [31:0] span_end;
   logic [8:0]  idx;
   logic [40:0] fresh_pn;
   logic [63:0] entry;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[3]) begin
         top_ff <= csr_pwdata[51:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[3] ? 64'd0 : {12'd0, top_ff};

   // Table memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   // Request checks, in priority order.
   assign va_off   = req_data.huge_pages ? req_data.virt_addr[29:0]
                                         : {9'd0, req_data.virt_addr[20:0]};
   assign span_end = {2'd0, va_off} + {1'b0, req_data.span_bytes};

   // Table index for the current level.
   always_comb begin
      case (level_ff)
         LV_PML4: idx = va_ff[35:27];
         LV_PDP:  idx = va_ff[26:18];
         LV_PD:   idx = va_ff[17:9];
         default: idx = (huge_ff ? va_ff[17:9] : va_ff[8:0]) + cnt_ff[8:0];
      endcase
   end

   // Fresh table page for an absent entry at this level.
   always_comb begin
      case (level_ff)
         LV_PML4: fresh_pn = {1'b0, tb_pn_ff};
         LV_PDP:  fresh_pn = {1'b0, tb_pn_ff} + 41'd1;
         default: fresh_pn = {1'b0, tb_pn_ff} + 41'd2;
      endcase
   end

   assign entry = mem_rdata_ff;

   // Walk sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      level_in     = level_ff;
      cur_pn_in    = cur_pn_ff;
      tb_pn_in     = tb_pn_ff;
      leaf_pn_in   = leaf_pn_ff;
      va_in        = va_ff;
      rw_in        = rw_ff;
      huge_in      = huge_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_addr     = {cur_pn_ff[AW-10:0], idx};
      mem_wdata    = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               va_in      = req_data.virt_addr[47:12];
               tb_pn_in   = req_data.table_base[51:12];
               leaf_pn_in = req_data.phys_addr[51:12];
               rw_in      = req_data.writable;
               huge_in    = req_data.huge_pages;
               n_in       = req_data.huge_pages ? req_data.span_bytes[30:21]
                                                : req_data.span_bytes[21:12];
               cnt_in     = '0;
               level_in   = LV_PML4;
               cur_pn_in  = {1'b0, top_ff[51:12]};
               rsp_in.leaves_written = '0;
               if (!req_data.skip_vaddr_align && va_off != 30'd0) begin
                  rsp_in.status = ST_VADDR_ALIGN;
                  rsp_valid_in  = 1'b1;
               end else if (req_data.huge_pages ? req_data.span_bytes[20:0] != 21'd0
                                                : req_data.span_bytes[11:0] != 12'd0) begin
                  rsp_in.status = ST_SIZE_ALIGN;
                  rsp_valid_in  = 1'b1;
               end else if (req_data.huge_pages ? req_data.phys_addr[20:0] != 21'd0
                                                : req_data.phys_addr[11:0] != 12'd0) begin
                  rsp_in.status = ST_PADDR_ALIGN;
                  rsp_valid_in  = 1'b1;
               end else if (span_end > (req_data.huge_pages ? REACH_HUGE : REACH_SMALL)) begin
                  rsp_in.status = ST_SPAN;
                  rsp_valid_in  = 1'b1;
               end else begin
                  state_in = S_RD;
               end
            end
         end

         // Check that the table page fits and finish once every leaf is written, else read its entry.
         S_RD: begin
            if (cur_pn_ff > PN_MAX) begin
               rsp_in.status = ST_NO_MEMORY;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (level_ff == LV_LEAF && cnt_ff == n_ff) begin
               rsp_in.status = ST_OK;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_WR;
            end
         end

         // Write back the entry just read, or stop on a present leaf or a huge PD entry.
         S_WR: begin
            if (level_ff == LV_LEAF) begin
               if (entry[0]) begin
                  rsp_in.status = ST_PRESENT;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  mem_we     = 1'b1;
                  mem_wdata  = {12'd0, leaf_pn_ff, 4'd0, huge_ff, 5'd0, rw_ff, 1'b1};
                  cnt_in     = cnt_ff + 10'd1;
                  rsp_in.leaves_written = cnt_ff + 10'd1;
                  leaf_pn_in = leaf_pn_ff + (huge_ff ? 40'd512 : 40'd1);
                  state_in   = S_RD;
               end
            end else if (level_ff == LV_PD && !huge_ff && entry[0] && entry[7]) begin
               rsp_in.status = ST_UNDER_HUGE;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               mem_we = 1'b1;
               if (entry[0]) begin
                  mem_wdata = entry | {62'd0, rw_ff, 1'b0};
                  cur_pn_in = {1'b0, entry[51:12]};
               end else begin
                  mem_wdata = {11'd0, fresh_pn, 10'd0, rw_ff, 1'b1};
                  cur_pn_in = fresh_pn;
               end
               case (level_ff)
                  LV_PML4: level_in = LV_PDP;
                  LV_PDP:  level_in = huge_ff ? LV_LEAF : LV_PD;
                  default: level_in = LV_LEAF;
               endcase
               state_in = S_RD;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and walk payload registers.
   always_ff @(posedge clock) begin
      level_ff   <= level_in;
      cur_pn_ff  <= cur_pn_in;
      tb_pn_ff   <= tb_pn_in;
      leaf_pn_ff <= leaf_pn_in;
      va_ff      <= va_in;
      rw_ff      <= rw_in;
      huge_ff    <= huge_in;
      n_ff       <= n_in;
      cnt_ff     <= cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/ptmi_check.sv
// ----------------------------------------------------------------------------
// Page table mapping inserter checker
// Port-level assertions on the inserter, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmi_check
   import ptmi_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // An accepted request either starts a walk or is answered at once.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted request neither walked nor answered");

   // A result only follows an accepted request or busy work.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result without a request in flight");

   // A failed check writes no leaves.
   a_check_no_leaves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_VADDR_ALIGN || rsp_data.status == ST_SIZE_ALIGN
         || rsp_data.status == ST_PADDR_ALIGN || rsp_data.status == ST_SPAN)
      |-> rsp_data.leaves_written == 10'd0)
      else $error("leaves reported for a rejected request");

   // One table holds at most 512 leaves.
   a_leaf_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.leaves_written <= 10'd512)
      else $error("leaf count out of range");

endmodule

bind page_table_mapping_inserter ptmi_check u_ptmi_check (.*);

`default_nettype wire

FILE: test/page_table_mapping_inserter_tb.sv
// ----------------------------------------------------------------------------
// Page table mapping inserter testbench
// Sends mapping requests through the start/busy port and predicts each
// status and leaf count with a private copy of the table memory. Results
// are checked in order as they strobe out. The run covers directed corner
// cases and random phases with several top table bases and idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_mapping_inserter_tb;
   import ptmi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] ENT_ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
   localparam logic [63:0] ADDR52_MASK   = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] ENT_P         = 64'h1;
   localparam logic [63:0] ENT_RW        = 64'h2;
   localparam logic [63:0] ENT_PS        = 64'h80;
   localparam logic [3:0]  REG_TOP_BASE  = 4'd0;
   localparam longint      CYCLE_LIMIT   = 10000000;
   localparam int          REQ_BITS      = $bits(req_type);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // Private copy of the table memory and the top table register.
   logic [63:0] shadow_table [TableMemWords];
   logic [63:0] shadow_top_base;
   rsp_type     pending_results [$];
   int          failures = 0;
   int          results_seen = 0;
   int          status_seen [8];
   int          idle_percent = 0;
   longint      cycles = 0;

   page_table_mapping_inserter DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // A table page is usable only if it lies wholly within the memory.
   function automatic bit page_fits(input logic [63:0] base);
      return (base >> 3) <= 64'(TableMemWords - TableEntries);
   endfunction

   function automatic int entry_index(input logic [63:0] base, input logic [63:0] va,
                                      input int shift);
      return int'((base >> 3) + ((va >> shift) & 64'd511));
   endfunction

   // Walks PML4, PDP and PD, then writes leaves; updates the shadow table.
   function automatic logic [2:0] walk_tables(input logic [63:0] va, input logic [63:0] pa,
                                              input logic [63:0] sz, input logic [63:0] tb,
                                              input logic [63:0] rw, input bit huge,
                                              output logic [9:0] leaves);
      logic [63:0] pml4, pdp, pd, pt, ent, off;
      int          w;
      pml4 = shadow_top_base & ENT_ADDR_MASK;
      pdp = tb;
      pd = tb + PAGE_BYTES;
      pt = pd + PAGE_BYTES;
      leaves = '0;
      if (!page_fits(pml4)) return ST_NO_MEMORY;
      w = entry_index(pml4, va, 39);
      ent = shadow_table[w];
      if (ent & ENT_P) pdp = ent & ENT_ADDR_MASK; else ent = pdp | ENT_P;
      shadow_table[w] = ent | rw;
      if (!page_fits(pdp)) return ST_NO_MEMORY;
      w = entry_index(pdp, va, 30);
      ent = shadow_table[w];
      if (ent & ENT_P) pd = ent & ENT_ADDR_MASK; else ent = pd | ENT_P;
      shadow_table[w] = ent | rw;
      if (!page_fits(pd)) return ST_NO_MEMORY;
      if (huge) begin
         for (off = 0; off < sz; off += HUGE_BYTES) begin
            w = entry_index(pd, va + off, 21);
            if (shadow_table[w] & ENT_P) return ST_PRESENT;
            shadow_table[w] = ((pa + off) & ENT_ADDR_MASK) | ENT_P | rw | ENT_PS;
            leaves++;
         end
         return ST_OK;
      end
      w = entry_index(pd, va, 21);
      ent = shadow_table[w];
      if ((ent & ENT_P) && (ent & ENT_PS)) return ST_UNDER_HUGE;
      if (ent & ENT_P) pt = ent & ENT_ADDR_MASK; else ent = pt | ENT_P;
      shadow_table[w] = ent | rw;
      if (!page_fits(pt)) return ST_NO_MEMORY;
      for (off = 0; off < sz; off += PAGE_BYTES) begin
         w = entry_index(pt, va + off, 12);
         if (shadow_table[w] & ENT_P) return ST_PRESENT;
         shadow_table[w] = ((pa + off) & ENT_ADDR_MASK) | ENT_P | rw;
         leaves++;
      end
      return ST_OK;
   endfunction

   // Expected result of one mapping request.
   function automatic rsp_type predict_mapping(input req_type r);
      logic [63:0] va, pa, sz, tb, rw, unit, reach;
      rsp_type     res;
      va = r.virt_addr;
      pa = {12'b0, r.phys_addr};
      sz = {33'b0, r.span_bytes};
      tb = {12'b0, r.table_base} & ENT_ADDR_MASK;
      rw = r.writable ? ENT_RW : 64'd0;
      unit = r.huge_pages ? HUGE_BYTES : PAGE_BYTES;
      reach = r.huge_pages ? 64'(TableEntries) * HUGE_BYTES : HUGE_BYTES;
      res.leaves_written = '0;
      if (!r.skip_vaddr_align && (va & (reach - 1)) != 0) res.status = ST_VADDR_ALIGN;
      else if ((sz & (unit - 1)) != 0) res.status = ST_SIZE_ALIGN;
      else if ((pa & (unit - 1)) != 0) res.status = ST_PADDR_ALIGN;
      else if ((va & (reach - 1)) + sz > reach) res.status = ST_SPAN;
      else res.status = walk_tables(va, pa, sz, tb, rw, r.huge_pages, res.leaves_written);
      return res;
   endfunction

   function automatic req_type make_req(input logic [63:0] va, input logic [51:0] pa,
                                        input logic [30:0] sz, input logic [51:0] tb,
                                        input bit wr, input bit huge, input bit skip);
      req_type r;
      r.virt_addr = va;
      r.phys_addr = pa;
      r.span_bytes = sz;
      r.table_base = tb;
      r.writable = wr;
      r.huge_pages = huge;
      r.skip_vaddr_align = skip;
      return r;
   endfunction

   // Random request: mostly well-formed mappings into a few table regions.
   function automatic req_type random_mapping();
      req_type     r;
      logic [63:0] va;
      int          pages, first;
      bit          huge;
      if ($urandom_range(0, 99) < 15) begin
         r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom});
         return r;
      end
      huge = ($urandom_range(0, 3) == 0);
      pages = ($urandom_range(0, 49) == 0) ? 512 : $urandom_range(0, 8);
      first = (pages == 512) ? 0 : $urandom_range(0, 511 - pages);
      va = {$urandom, $urandom};
      va[47:39] = ($urandom_range(0, 2) == 0) ? 9'($urandom) : 9'($urandom_range(0, 3));
      va[38:30] = ($urandom_range(0, 2) == 0) ? 9'($urandom) : 9'($urandom_range(0, 3));
      if (huge) begin
         va[29:21] = 9'(first);
         va[20:0] = '0;
      end else begin
         va[29:21] = 9'($urandom_range(0, 7));
         va[20:12] = 9'(first);
         va[11:0] = '0;
      end
      r.skip_vaddr_align = ($urandom_range(0, 7) == 0);
      if (r.skip_vaddr_align && !huge) va[11:0] = 12'($urandom);
      r.virt_addr = va;
      r.huge_pages = huge;
      r.span_bytes = 31'(pages * (huge ? HUGE_BYTES : PAGE_BYTES));
      r.phys_addr = 52'({$urandom, $urandom}) & (huge ? ~52'h1F_FFFF : ~52'hFFF);
      r.table_base = ($urandom_range(0, 19) == 0) ? 52'({$urandom, $urandom})
                                                  : 52'($urandom_range(1, 127)) << 12;
      r.writable = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Sends one request and records its expected result at acceptance.
   task automatic send_mapping(input req_type r);
      @(negedge clock);
      start = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      pending_results.push_back(predict_mapping(r));
      if ($urandom_range(0, 99) < idle_percent) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   // Waits until every expected result has arrived, then lets the block settle.
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      wait (pending_results.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_top_base(input logic [63:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = REG_TOP_BASE;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      shadow_top_base = value & ADDR52_MASK;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Result checker: each strobe is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding: status %0d", rsp_data.status);
            failures++;
         end else begin
            exp_rsp = pending_results.pop_front();
            results_seen++;
            status_seen[rsp_data.status]++;
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.leaves_written !== exp_rsp.leaves_written) begin
               $error("leaves_written: expected %0d, actual %0d",
                      exp_rsp.leaves_written, rsp_data.leaves_written);
               failures++;
            end
         end
      end
   end

   // Checks, walk cases, leaf limits and address extremes.
   task automatic test_directed();
      idle_percent = 0;
      write_top_base(64'h0);
      send_mapping(make_req(64'h1000, 0, 31'h1000, 52'h1000, 1, 0, 0));
      send_mapping(make_req(64'h1234, 0, 31'h1000, 52'h1000, 1, 0, 1));
      send_mapping(make_req(64'h200000, 0, 31'h800, 52'h1000, 1, 0, 0));
      send_mapping(make_req(64'h200000, 52'h10, 31'h1000, 52'h1000, 1, 0, 0));
      send_mapping(make_req(64'h0, 0, 31'h201000, 52'h1000, 1, 0, 0));
      send_mapping(make_req(64'h200000, 52'h5000, 31'h4000, 52'h1000, 1, 0, 0));
      send_mapping(make_req(64'h200000, 52'h5000, 31'h4000, 52'h1000, 0, 0, 0));
      send_mapping(make_req(64'h4000_0000, 52'h20_0000, 31'h40_0000, 52'h4000, 1, 1, 0));
      send_mapping(make_req(64'h4000_0000, 0, 31'h1000, 52'h4000, 1, 0, 0));
      send_mapping(make_req(64'h60_0000, 0, 31'h0, 52'h1000, 0, 0, 0));
      send_mapping(make_req(64'h0000_0180_0000_0000, 0, 31'h1000,
                            52'hF_FFFF_FFFF_FFFF, 1, 0, 0));
      send_mapping(make_req(64'h0000_0080_0000_0000, 52'h1_2340_0000, 31'h20_0000,
                            52'h8000, 1, 0, 0));
      send_mapping(make_req(64'h0000_0100_0000_0000, 52'hA_0000_0000, 31'h4000_0000,
                            52'hC000, 0, 1, 0));
      send_mapping(make_req(64'h40_0000, 52'hF_FFFF_FFFF_F000, 31'h2000, 52'h1000, 1, 0, 0));
      send_mapping(make_req(64'hFFFF_FF80_0000_0000, 52'h7000, 31'h3000, 52'h10000, 1, 0, 0));
      send_mapping(make_req(64'hFFFF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF,
                            52'hF_FFFF_FFFF_FFFF, 1, 1, 0));
      send_mapping(make_req(64'h4020_0000, 52'h20_0000, 31'h20_0000, 52'h4000, 1, 1, 0));
      drain_results();
      // Top table outside memory, then a base with stray low bits.
      write_top_base(64'hFFFF_FFFF_FFFF_FFFF);
      send_mapping(make_req(64'h80_0000, 0, 31'h1000, 52'h1000, 1, 0, 0));
      drain_results();
      write_top_base(64'hFFF);
      send_mapping(make_req(64'h80_0000, 0, 31'h1000, 52'h1000, 1, 0, 0));
      drain_results();
   endtask

   task automatic test_random_phase(input logic [63:0] top_base, input int idle,
                                    input int count);
      write_top_base(top_base);
      idle_percent = idle;
      repeat (count) send_mapping(random_mapping());
      drain_results();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_phase(64'h0, 0, 500);
      test_random_phase(64'h7F000, 81, 450);
      test_random_phase(64'h3_0000, 28, 500);
      wait (pending_results.size() == 0);
      repeat (16) @(posedge clock);
      $display("Checked %0d results: ok %0d, present %0d, under huge %0d, no memory %0d,",
               results_seen, status_seen[ST_OK], status_seen[ST_PRESENT],
               status_seen[ST_UNDER_HUGE], status_seen[ST_NO_MEMORY]);
      $display("  misaligned or oversized %0d, over four top table bases.",
               status_seen[1] + status_seen[2] + status_seen[3] + status_seen[4]);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      foreach (shadow_table[i]) shadow_table[i] = '0;
      shadow_top_base = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/ptmi_pkg.sv
rtl/page_table_mapping_inserter.sv
rtl/ptmi_check.sv
test/page_table_mapping_inserter_tb.sv
